// ===== rtl/core/bmpu_pkg.sv =====
package bmpu_pkg;

  localparam int unsigned MaxWidthDefault   = 4096;
  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned CfgIdxW           = 1;
  localparam int unsigned CfgDataW          = 13;

  typedef enum logic [0:0] {
    OpPalette = 1'b0,
    OpData    = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPixelFormat = 1'b0,
    CfgRowWidth    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    Fmt1Bpp  = 3'd0,
    Fmt4Bpp  = 3'd1,
    Fmt8Bpp  = 3'd2,
    Fmt24Bpp = 3'd3,
    Fmt32Bpp = 3'd4
  } fmt_e;

  localparam fmt_e                FmtReset      = Fmt8Bpp;
  localparam logic [CfgDataW-1:0] RowWidthReset = 13'd1024;
  localparam logic [7:0]          AlphaOpaque   = 8'hff;

  typedef struct packed {
    logic       opcode;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic        fire;
    logic        use_table;
    logic [7:0]  idx;
    logic [23:0] rgb;
    logic        row_end;
    logic        last;
  } pix_req_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  idx;
    logic [23:0] rgb;
  } pal_wr_t;

  function automatic fmt_e decode_fmt(logic [2:0] raw);
    fmt_e f;
    unique case (raw)
      Fmt1Bpp:  f = Fmt1Bpp;
      Fmt4Bpp:  f = Fmt4Bpp;
      Fmt24Bpp: f = Fmt24Bpp;
      Fmt32Bpp: f = Fmt32Bpp;
      default:  f = Fmt8Bpp;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/bmpu_palette.sv =====
module bmpu_palette #(
  parameter int unsigned TABLE_DEPTH = bmpu_pkg::TableDepthDefault
) (
  input  logic              clk_i,
  input  bmpu_pkg::pal_wr_t wr_i,
  input  logic              rd_en_i,
  input  logic [7:0]        rd_idx_i,
  output logic [23:0]       rd_data_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [23:0] mem [TABLE_DEPTH];
  logic [23:0] rd_q;
  logic        rd_oob_q;
  logic        wr_in_range;
  logic        rd_in_range;

  assign wr_in_range = 32'(wr_i.idx) < TABLE_DEPTH;
  assign rd_in_range = 32'(rd_idx_i) < TABLE_DEPTH;

  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_in_range) begin
      mem[wr_i.idx[IdxW-1:0]] <= wr_i.rgb;
    end
    if (rd_en_i) begin
      rd_q     <= mem[rd_idx_i[IdxW-1:0]];
      rd_oob_q <= !rd_in_range;
    end
  end

  assign rd_data_o = rd_oob_q ? 24'd0 : rd_q;

endmodule

// ===== rtl/core/bmpu_unpack.sv =====
module bmpu_unpack #(
  parameter int unsigned MAX_WIDTH = bmpu_pkg::MaxWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bmpu_pkg::in_item_t              in_data_i,
  input  logic                            cfg_we_i,
  input  logic [bmpu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bmpu_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            out_free_i,
  output bmpu_pkg::pix_req_t              req_o,
  output bmpu_pkg::pal_wr_t               pal_wr_o
);

  localparam int unsigned PixW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ByteW = PixW + 2;
  localparam int unsigned BitsW = PixW + 5;

  function automatic logic [PixW-1:0] eff_width_f(logic [bmpu_pkg::CfgDataW-1:0] w);
    logic [PixW-1:0] r;
    if (w == '0) begin
      r = PixW'(1);
    end else if (32'(w) > MAX_WIDTH) begin
      r = PixW'(MAX_WIDTH);
    end else begin
      r = PixW'(w);
    end
    return r;
  endfunction

  function automatic logic [ByteW-1:0] row_bytes_f(bmpu_pkg::fmt_e fmt, logic [PixW-1:0] w);
    logic [BitsW-1:0] wx;
    logic [BitsW-1:0] bits;
    logic [BitsW-1:0] rnd;
    wx = BitsW'(w);
    case (fmt)
      bmpu_pkg::Fmt1Bpp:  bits = wx;
      bmpu_pkg::Fmt4Bpp:  bits = wx << 2;
      bmpu_pkg::Fmt24Bpp: bits = (wx << 4) + (wx << 3);
      bmpu_pkg::Fmt32Bpp: bits = wx << 5;
      default:            bits = wx << 3;
    endcase
    rnd = bits + BitsW'(31);
    return {rnd[BitsW-1:5], 2'b00};
  endfunction

  bmpu_pkg::fmt_e     fmt_q;
  logic [PixW-1:0]    effw_q;
  logic [ByteW-1:0]   row_bytes_q;

  logic               hold_q;
  bmpu_pkg::in_item_t item_q;

  logic [PixW-1:0]    pix_q, pix_d;
  logic [ByteW-1:0]   byte_q, byte_d;
  logic [2:0]         sub_q, sub_d;
  logic [1:0]         phase_q, phase_d;
  logic [15:0]        part_q, part_d;

  logic               is_data;
  logic               rgb_mode;
  logic               has_pix;
  logic               row_end;
  logic               last_sub;
  logic               emit;
  logic               byte_last;
  logic               step;
  logic [7:0]         idx;
  logic [ByteW-1:0]   byte_inc;
  logic [7:0]         b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= bmpu_pkg::FmtReset;
      effw_q      <= eff_width_f(bmpu_pkg::RowWidthReset);
      row_bytes_q <= row_bytes_f(bmpu_pkg::FmtReset, eff_width_f(bmpu_pkg::RowWidthReset));
    end else begin
      row_bytes_q <= row_bytes_f(fmt_q, effw_q);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bmpu_pkg::CfgPixelFormat: fmt_q  <= bmpu_pkg::decode_fmt(cfg_data_i[2:0]);
          bmpu_pkg::CfgRowWidth:    effw_q <= eff_width_f(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  assign b        = item_q.data_byte;
  assign is_data  = item_q.opcode == bmpu_pkg::OpData;
  assign has_pix  = pix_q < effw_q;
  assign row_end  = (pix_q + PixW'(1)) == effw_q;
  assign byte_inc = byte_q + ByteW'(1);

  always_comb begin
    rgb_mode = 1'b0;
    last_sub = 1'b1;
    idx      = b;
    case (fmt_q)
      bmpu_pkg::Fmt1Bpp: begin
        idx      = {7'd0, b[3'd7 - sub_q]};
        last_sub = sub_q == 3'd7;
      end
      bmpu_pkg::Fmt4Bpp: begin
        idx      = sub_q[0] ? {4'd0, b[3:0]} : {4'd0, b[7:4]};
        last_sub = sub_q[0];
      end
      bmpu_pkg::Fmt24Bpp, bmpu_pkg::Fmt32Bpp: begin
        rgb_mode = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (!is_data) begin
      emit      = 1'b0;
      byte_last = 1'b1;
    end else if (rgb_mode) begin
      emit      = (phase_q == 2'd2) && has_pix;
      byte_last = 1'b1;
    end else begin
      emit      = has_pix;
      byte_last = !has_pix || last_sub || row_end;
    end
  end

  assign step       = hold_q && (!emit || out_free_i);
  assign in_ready_o = !hold_q || (step && byte_last);

  always_comb begin
    req_o.fire      = step && emit;
    req_o.use_table = !rgb_mode;
    req_o.idx       = idx;
    req_o.rgb       = {b, part_q};
    req_o.row_end   = row_end;
    req_o.last      = rgb_mode || byte_last;
  end

  always_comb begin
    pal_wr_o.we  = step && !is_data;
    pal_wr_o.idx = item_q.palette_index;
    pal_wr_o.rgb = {item_q.palette_red, item_q.palette_green, item_q.palette_blue};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  always_comb begin
    pix_d   = pix_q;
    byte_d  = byte_q;
    sub_d   = sub_q;
    phase_d = phase_q;
    part_d  = part_q;
    if (step && is_data) begin
      if (emit) begin
        pix_d = pix_q + PixW'(1);
      end
      if (rgb_mode) begin
        case (phase_q)
          2'd0:    part_d = {8'h00, b};
          2'd1:    part_d = {b, part_q[7:0]};
          default: ;
        endcase
        if (fmt_q == bmpu_pkg::Fmt24Bpp && phase_q == 2'd2) begin
          phase_d = 2'd0;
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end else begin
        sub_d = byte_last ? 3'd0 : sub_q + 3'd1;
      end
      if (byte_last) begin
        byte_d = byte_inc;
        if (byte_inc >= row_bytes_q) begin
          pix_d   = '0;
          byte_d  = '0;
          sub_d   = '0;
          phase_d = '0;
          part_d  = '0;
        end
      end
    end
    if (cfg_we_i) begin
      pix_d   = '0;
      byte_d  = '0;
      sub_d   = '0;
      phase_d = '0;
      part_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q   <= '0;
      byte_q  <= '0;
      sub_q   <= '0;
      phase_q <= '0;
      part_q  <= '0;
    end else begin
      pix_q   <= pix_d;
      byte_q  <= byte_d;
      sub_q   <= sub_d;
      phase_q <= phase_d;
      part_q  <= part_d;
    end
  end

endmodule

// ===== rtl/core/bmp_row_pixel_unpacker.sv =====
// Channel | Dir | Handshake              | Beat payload
// in      | in  | in_valid_i/in_ready_o  | in_data_i   (palette write or one row byte)
// out     | out | out_valid_o/out_ready_i| out_data_o  (one RGBA pixel)
// cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
// One input beat per cycle for palette writes, padding bytes and 8/24/32 bpp bytes
// while the output is not stalled. A 1 bpp byte yields up to 8 pixels, a 4 bpp byte up
// to 2: the unpack stage emits one pixel per cycle through the single palette read port.
// Beats register in unpack, pixels at the output. Output stalls hold the unpack stage.
// Reset clears the row position and sets 8 bpp, 1024 pixels; the palette is not cleared.
module bmp_row_pixel_unpacker #(
  parameter int unsigned MAX_WIDTH   = bmpu_pkg::MaxWidthDefault,
  parameter int unsigned TABLE_DEPTH = bmpu_pkg::TableDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bmpu_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bmpu_pkg::out_item_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bmpu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bmpu_pkg::CfgDataW-1:0]  cfg_data_i
);

  bmpu_pkg::pix_req_t req;
  bmpu_pkg::pal_wr_t  pal_wr;
  logic               out_free;
  logic [23:0]        pal_rgb;
  logic [23:0]        rgb;

  logic               out_valid_q;
  logic               use_table_q;
  logic [23:0]        rgb_q;
  logic               row_end_q;
  logic               last_q;

  assign out_free = !out_valid_q || out_ready_i;

  bmpu_unpack #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_unpack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_free_i (out_free),
    .req_o      (req),
    .pal_wr_o   (pal_wr)
  );

  bmpu_palette #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_i      (pal_wr),
    .rd_en_i   (req.fire && req.use_table),
    .rd_idx_i  (req.idx),
    .rd_data_o (pal_rgb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= req.fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.fire) begin
      use_table_q <= req.use_table;
      rgb_q       <= req.rgb;
      row_end_q   <= req.row_end;
      last_q      <= req.last;
    end
  end

  assign rgb         = use_table_q ? pal_rgb : rgb_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    out_data_o.red         = rgb[23:16];
    out_data_o.green       = rgb[15:8];
    out_data_o.blue        = rgb[7:0];
    out_data_o.alpha       = bmpu_pkg::AlphaOpaque;
    out_data_o.row_end     = row_end_q;
    out_data_o.last_of_run = last_q;
  end

  a_no_fire_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.fire && out_valid_q && !out_ready_i))
    else $error("pixel issued while output beat stalled");

  a_row_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.row_end |-> out_data_o.last_of_run)
    else $error("row end without last of run");

  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.fire |=> out_valid_o)
    else $error("issued pixel lost");

  a_pal_write_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_wr.we |-> !req.fire)
    else $error("palette write produced a pixel");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned DrainWait  = 16;
  localparam int unsigned RandBeats  = 480;
  localparam int unsigned CfgW       = bmpu_pkg::CfgDataW;
  localparam logic [2:0]  FmtUnknown = 3'd7;

  typedef struct {
    bit                            is_reg;
    bmpu_pkg::cfg_idx_e            reg_sel;
    logic [bmpu_pkg::CfgDataW-1:0] reg_val;
    bmpu_pkg::in_item_t            beat;
    bit                            typed;
    bmpu_pkg::out_item_t           want;
  } plan_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  bmpu_pkg::in_item_t            in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  bmpu_pkg::out_item_t           out_data_o;
  logic                          cfg_we_i;
  logic [bmpu_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [bmpu_pkg::CfgDataW-1:0] cfg_data_i;

  // predictor state
  logic [23:0]                   pal_rgb [256];
  bit                            pal_set [256];
  logic [7:0]                    pal_any_q [$];
  logic [3:0]                    pal_low_q [$];
  logic [2:0]                    fmt_cur;
  logic [bmpu_pkg::CfgDataW-1:0] width_cur;
  int unsigned                   byte_pos;
  int unsigned                   px_pos;
  logic [23:0]                   partial_rgb;
  int unsigned                   bgr_phase;

  bmpu_pkg::out_item_t           pixel_q [$];
  plan_row_t                     plan_q [$];
  bmpu_pkg::out_item_t           got_px;
  bmpu_pkg::out_item_t           want_px;
  int unsigned                   err_cnt;
  int unsigned                   beats_in;
  int unsigned                   pal_beats;
  int unsigned                   px_checked;
  int unsigned                   reg_writes;
  int unsigned                   idle_cycles;
  bit                            src_calm;
  bit                            sink_calm;

  bmp_row_pixel_unpacker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < 50) begin
      $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    end
    err_cnt++;
  endtask

  function automatic int unsigned bits_per_px();
    case (fmt_cur)
      bmpu_pkg::Fmt1Bpp:  return 1;
      bmpu_pkg::Fmt4Bpp:  return 4;
      bmpu_pkg::Fmt24Bpp: return 24;
      bmpu_pkg::Fmt32Bpp: return 32;
      default:            return 8;
    endcase
  endfunction

  function automatic void restart_row();
    byte_pos    = 0;
    px_pos      = 0;
    partial_rgb = '0;
    bgr_phase   = 0;
  endfunction

  function automatic int unsigned unpack_predict(bmpu_pkg::in_item_t beat, bit keep);
    int unsigned         bpp;
    int unsigned         w;
    int unsigned         row_bytes;
    int unsigned         n;
    logic [7:0]          c;
    logic [7:0]          idx;
    logic [23:0]         rgb;
    bmpu_pkg::out_item_t px;
    n = 0;
    if (beat.opcode == bmpu_pkg::OpPalette) begin
      idx = beat.palette_index;
      if (!pal_set[idx]) begin
        pal_set[idx] = 1'b1;
        pal_any_q.push_back(idx);
        if (idx < 16) pal_low_q.push_back(idx[3:0]);
      end
      pal_rgb[idx] = {beat.palette_red, beat.palette_green, beat.palette_blue};
      return 0;
    end
    bpp = bits_per_px();
    w = (width_cur == 0) ? 1 :
        ((width_cur > bmpu_pkg::MaxWidthDefault) ? bmpu_pkg::MaxWidthDefault : width_cur);
    row_bytes = 4 * ((bpp * w + 31) / 32);
    if (bpp <= 8) begin
      c = beat.data_byte;
      for (int i = 0; i < 8 / bpp && px_pos < w; i++) begin
        case (bpp)
          1:       idx = {7'd0, c[7]};
          4:       idx = {4'd0, c[7:4]};
          default: idx = c;
        endcase
        c = c << bpp;
        px_pos++;
        rgb = pal_rgb[idx];
        px = '{red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
               alpha: bmpu_pkg::AlphaOpaque, row_end: (px_pos == w), last_of_run: 1'b0};
        if (keep) pixel_q.push_back(px);
        n++;
      end
    end else begin
      case (bgr_phase)
        0: partial_rgb = {16'd0, beat.data_byte};
        1: partial_rgb = {8'd0, beat.data_byte, partial_rgb[7:0]};
        2: begin
          partial_rgb = {beat.data_byte, partial_rgb[15:0]};
          if (px_pos < w) begin
            px_pos++;
            px = '{red: partial_rgb[23:16], green: partial_rgb[15:8],
                   blue: partial_rgb[7:0], alpha: bmpu_pkg::AlphaOpaque,
                   row_end: (px_pos == w), last_of_run: 1'b0};
            if (keep) pixel_q.push_back(px);
            n++;
          end
        end
        default: ;
      endcase
      bgr_phase++;
      if (bgr_phase >= ((bpp == 24) ? 3 : 4)) bgr_phase = 0;
    end
    if (keep && n > 0) pixel_q[pixel_q.size() - 1].last_of_run = 1'b1;
    byte_pos++;
    if (byte_pos >= row_bytes) restart_row();
    return n;
  endfunction

  function automatic plan_row_t blank_row();
    plan_row_t r;
    r.is_reg  = 1'b0;
    r.reg_sel = bmpu_pkg::CfgPixelFormat;
    r.reg_val = '0;
    r.beat    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic void reg_row(bmpu_pkg::cfg_idx_e sel,
                                  logic [bmpu_pkg::CfgDataW-1:0] val);
    plan_row_t r;
    r = blank_row();
    r.is_reg  = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    plan_q.push_back(r);
  endfunction

  function automatic void pal_row(logic [7:0] idx, logic [7:0] rr, logic [7:0] gg,
                                  logic [7:0] bb);
    plan_row_t r;
    r = blank_row();
    r.beat = '{opcode: bmpu_pkg::OpPalette, palette_index: idx, palette_red: rr,
               palette_green: gg, palette_blue: bb, data_byte: 8'h00};
    plan_q.push_back(r);
  endfunction

  function automatic void byte_row(logic [7:0] data);
    plan_row_t r;
    r = blank_row();
    r.beat = '{opcode: bmpu_pkg::OpData, palette_index: 8'h00, palette_red: 8'h00,
               palette_green: 8'h00, palette_blue: 8'h00, data_byte: data};
    plan_q.push_back(r);
  endfunction

  function automatic void byte_want(logic [7:0] data, logic [7:0] rr, logic [7:0] gg,
                                    logic [7:0] bb, logic re);
    byte_row(data);
    plan_q[plan_q.size() - 1].typed = 1'b1;
    plan_q[plan_q.size() - 1].want = '{red: rr, green: gg, blue: bb,
                                       alpha: bmpu_pkg::AlphaOpaque,
                                       row_end: re, last_of_run: 1'b1};
  endfunction

  task automatic send_item(bmpu_pkg::in_item_t beat);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    beats_in++;
    if (beat.opcode == bmpu_pkg::OpPalette) pal_beats++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(bmpu_pkg::cfg_idx_e sel, logic [bmpu_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == bmpu_pkg::CfgPixelFormat) fmt_cur = val[2:0];
    else width_cur = val;
    restart_row();
    reg_writes++;
    @(posedge clk_i);
  endtask

  // sink: random backpressure per pixel
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_px = out_data_o;
      if (pixel_q.size() == 0) begin
        report("pixel with nothing pending",
               {8'd0, got_px.red, got_px.green, got_px.blue}, 32'd0);
      end else begin
        want_px = pixel_q.pop_front();
        if (got_px.red !== want_px.red) begin
          report("red", 32'(got_px.red), 32'(want_px.red));
        end
        if (got_px.green !== want_px.green) begin
          report("green", 32'(got_px.green), 32'(want_px.green));
        end
        if (got_px.blue !== want_px.blue) begin
          report("blue", 32'(got_px.blue), 32'(want_px.blue));
        end
        if (got_px.alpha !== want_px.alpha) begin
          report("alpha", 32'(got_px.alpha), 32'(want_px.alpha));
        end
        if (got_px.row_end !== want_px.row_end) begin
          report("row_end", 32'(got_px.row_end), 32'(want_px.row_end));
        end
        if (got_px.last_of_run !== want_px.last_of_run) begin
          report("last_of_run", 32'(got_px.last_of_run), 32'(want_px.last_of_run));
        end
      end
      px_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no beat for %0d cycles, %0d pixels pending", idle_cycles,
               pixel_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    bmpu_pkg::in_item_t            beat;
    logic [63:0]                   noise;
    plan_row_t                     row;
    int unsigned                   n;
    int unsigned                   bpp;
    int unsigned                   rand_beats;
    int unsigned                   phases;
    logic [bmpu_pkg::CfgDataW-1:0] wsel;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    err_cnt     = 0;
    beats_in    = 0;
    pal_beats   = 0;
    px_checked  = 0;
    reg_writes  = 0;
    idle_cycles = 0;
    src_calm    = 1'b0;
    sink_calm   = 1'b0;
    rand_beats  = 0;
    phases      = 0;
    foreach (pal_rgb[i]) begin
      pal_rgb[i] = '0;
      pal_set[i] = 1'b0;
    end
    fmt_cur   = bmpu_pkg::FmtReset;
    width_cur = bmpu_pkg::RowWidthReset;
    restart_row();

    pal_row(8'h00, 8'h00, 8'h00, 8'h00);
    pal_row(8'h01, 8'hff, 8'hff, 8'hff);
    pal_row(8'hff, 8'h12, 8'h34, 8'h56);
    pal_row(8'h0f, 8'ha5, 8'h5a, 8'hc3);
    pal_row(8'h80, 8'h80, 8'h01, 8'hfe);
    byte_want(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    byte_want(8'hff, 8'h12, 8'h34, 8'h56, 1'b0);
    byte_row(8'h80);
    reg_row(bmpu_pkg::CfgRowWidth, 13'd0);
    reg_row(bmpu_pkg::CfgPixelFormat, CfgW'(bmpu_pkg::Fmt24Bpp));
    byte_row(8'h00);
    byte_row(8'h00);
    byte_want(8'hff, 8'hff, 8'h00, 8'h00, 1'b1);
    byte_row(8'haa);
    reg_row(bmpu_pkg::CfgPixelFormat, CfgW'(bmpu_pkg::Fmt32Bpp));
    byte_row(8'h11);
    byte_row(8'h22);
    byte_want(8'h33, 8'h33, 8'h22, 8'h11, 1'b1);
    byte_row(8'hff);
    reg_row(bmpu_pkg::CfgPixelFormat, CfgW'(bmpu_pkg::Fmt1Bpp));
    reg_row(bmpu_pkg::CfgRowWidth, 13'd3);
    byte_row(8'hff);
    byte_row(8'h00);
    byte_row(8'h5a);
    byte_row(8'hff);
    reg_row(bmpu_pkg::CfgPixelFormat, CfgW'(bmpu_pkg::Fmt4Bpp));
    reg_row(bmpu_pkg::CfgRowWidth, 13'd8191);
    byte_row(8'hf0);
    reg_row(bmpu_pkg::CfgPixelFormat, CfgW'(FmtUnknown));
    reg_row(bmpu_pkg::CfgRowWidth, 13'd4096);
    byte_want(8'h0f, 8'ha5, 8'h5a, 8'hc3, 1'b0);
    byte_row(8'h01);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.is_reg) begin
        settle();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        send_item(row.beat);
        n = unpack_predict(row.beat, !row.typed);
        if (row.typed) begin
          if (n != 1) report("directed pixel count", n, 1);
          pixel_q.push_back(row.want);
        end
      end
    end

    while (rand_beats < RandBeats) begin
      settle();
      write_reg(bmpu_pkg::CfgPixelFormat, CfgW'($urandom_range(0, 7)));
      case ($urandom_range(0, 9))
        0:       wsel = 13'd0;
        1:       wsel = 13'd8191;
        2:       wsel = 13'd4096;
        3:       wsel = 13'd4095;
        default: wsel = CfgW'($urandom_range(1, 24));
      endcase
      write_reg(bmpu_pkg::CfgRowWidth, wsel);
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      phases++;
      repeat ($urandom_range(12, 40)) begin
        noise = {$urandom, $urandom};
        beat  = noise[$bits(bmpu_pkg::in_item_t)-1:0];
        if ($urandom_range(0, 99) < 12) begin
          beat.opcode = bmpu_pkg::OpPalette;
        end else begin
          beat.opcode = bmpu_pkg::OpData;
          bpp = bits_per_px();
          if (bpp == 8) begin
            beat.data_byte = pal_any_q[$urandom_range(0, pal_any_q.size() - 1)];
          end else if (bpp == 4) begin
            beat.data_byte = {pal_low_q[$urandom_range(0, pal_low_q.size() - 1)],
                              pal_low_q[$urandom_range(0, pal_low_q.size() - 1)]};
          end
        end
        send_item(beat);
        n = unpack_predict(beat, 1'b1);
        rand_beats++;
      end
    end

    src_calm  = 1'b0;
    sink_calm = 1'b0;
    settle();

    $display("ran %0d input beats (%0d palette writes) in %0d random settings",
             beats_in, pal_beats, phases);
    $display("checked %0d pixels across %0d register writes", px_checked, reg_writes);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
